// ===== rtl/core/ttbl_pkg.sv =====
`timescale 1ns / 1ps

package ttbl_pkg;

   localparam int TICK_BITS      = 48;
   localparam int TOKEN_BITS     = 16;
   localparam int DROP_BITS      = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LEVEL_BITS     = 2;
   localparam int ORIGIN_BITS    = 2;
   localparam int BUCKET_BITS    = 2;

   typedef logic [TICK_BITS-1:0]   tick_type;
   typedef logic [TOKEN_BITS-1:0]  token_type;
   typedef logic [DROP_BITS-1:0]   drop_type;
   typedef logic [LEVEL_BITS-1:0]  level_type;
   typedef logic [ORIGIN_BITS-1:0] origin_type;
   typedef logic [BUCKET_BITS-1:0] bucket_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NORMAL_BURST_MAIN     = 3'd0,
      CSR_PRIORITY_BURST_MAIN   = 3'd1,
      CSR_NORMAL_BURST_DAEMON   = 3'd2,
      CSR_PRIORITY_BURST_DAEMON = 3'd3,
      CSR_NORMAL_TICK_PERIOD    = 3'd4,
      CSR_PRIORITY_TICK_PERIOD  = 3'd5,
      CSR_PRIORITY_LEVEL_MIN    = 3'd6
   } csr_index_type;

   localparam token_type NORMAL_BURST_MAIN_RST     = 16'd256;
   localparam token_type PRIORITY_BURST_MAIN_RST   = 16'd64;
   localparam token_type NORMAL_BURST_DAEMON_RST   = 16'd128;
   localparam token_type PRIORITY_BURST_DAEMON_RST = 16'd32;
   localparam token_type NORMAL_TICK_PERIOD_RST    = 16'd250;
   localparam token_type PRIORITY_TICK_PERIOD_RST  = 16'd1000;
   localparam level_type PRIORITY_LEVEL_MIN_RST    = 2'd2;

   localparam origin_type ORIGIN_DAEMON = 2'd0;

   localparam bucket_type BUCKET_MAIN_NORMAL     = 2'd0;
   localparam bucket_type BUCKET_MAIN_PRIORITY   = 2'd1;
   localparam bucket_type BUCKET_DAEMON_NORMAL   = 2'd2;
   localparam bucket_type BUCKET_DAEMON_PRIORITY = 2'd3;

   localparam drop_type DROP_SATURATED = 32'hffff_ffff;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_REFILL,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic      start;
      token_type divisor;
   } div_ctl_type;

   typedef struct packed {
      logic     done;
      tick_type quotient;
   } div_sts_type;

endpackage

// ===== rtl/core/ttbl_req_if.sv =====
`timescale 1ns / 1ps

interface ttbl_req_if #(
   parameter int TIME_BITS = 48
);
   logic                   valid;
   logic                   ready;
   ttbl_pkg::level_type    level;
   ttbl_pkg::origin_type   origin_id;
   logic [TIME_BITS-1:0]   now_ms;

   modport source (output valid, output level, output origin_id, output now_ms, input ready);
   modport sink (input valid, input level, input origin_id, input now_ms, output ready);
endinterface

// ===== rtl/core/ttbl_rsp_if.sv =====
`timescale 1ns / 1ps

interface ttbl_rsp_if;
   logic                valid;
   logic                ready;
   logic                accepted;
   logic                used_priority;
   ttbl_pkg::drop_type  drops_flushed;

   modport source (output valid, output accepted, output used_priority,
                   output drops_flushed, input ready);
   modport sink (input valid, input accepted, input used_priority,
                 input drops_flushed, output ready);
endinterface

// ===== rtl/core/ttbl_div.sv =====
`timescale 1ns / 1ps

module ttbl_div #(
   parameter int TIME_BITS = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ttbl_pkg::div_ctl_type  ctl,
   input  logic [TIME_BITS-1:0]   dividend,
   output ttbl_pkg::div_sts_type  sts
);

   localparam int CW = $clog2(TIME_BITS + 1);
   localparam int QW = (TIME_BITS > ttbl_pkg::TICK_BITS) ? TIME_BITS : ttbl_pkg::TICK_BITS;
   localparam int TW = ttbl_pkg::TOKEN_BITS;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [TIME_BITS-1:0]  quo_ff, quo_in;
   logic [TW-1:0]         rem_ff, rem_in;
   logic [TW-1:0]         div_ff, div_in;

   logic [TW:0]           trial;
   logic [TW:0]           diff;
   logic                  fits;
   logic [QW-1:0]         quo_wide;

   // restoring division, one quotient bit per cycle; quotient shifts in behind the dividend
   always_comb begin
      trial = {rem_ff, quo_ff[TIME_BITS-1]};
      fits  = trial >= {1'b0, div_ff};
      diff  = trial - {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;

      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(TIME_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = ctl.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TIME_BITS-2:0], fits};
         rem_in = fits ? diff[TW-1:0] : trial[TW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quo_wide     = QW'(quo_ff);
   assign sts.done     = done_ff;
   assign sts.quotient = quo_wide[ttbl_pkg::TICK_BITS-1:0];

endmodule

// ===== rtl/core/two_tier_token_bucket_limiter.sv =====
`timescale 1ns / 1ps

// steps: from request transfer to response valid the request goes through ST_DIV,
// ST_REFILL and ST_DECIDE, and through them once more when the priority bucket is tried
// requests: one at a time; a new one is taken only after the response transfer, and
// each pass waits on the shared restoring divider that makes one tick bit per cycle
// reset: synchronous; configuration registers, bucket tokens (full burst), ticks and drop counts restored
module two_tier_token_bucket_limiter #(
   parameter int TIME_BITS = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ttbl_req_if.sink                              req,
   ttbl_rsp_if.source                            rsp,
   input  logic                                  csr_wr_en,
   input  logic [ttbl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ttbl_pkg::TOKEN_BITS-1:0]       csr_wdata
);

   localparam int TW = ttbl_pkg::TOKEN_BITS;

   ttbl_pkg::state_type   state_ff, state_in;

   ttbl_pkg::token_type   nb_main_ff, nb_main_in;
   ttbl_pkg::token_type   pb_main_ff, pb_main_in;
   ttbl_pkg::token_type   nb_daemon_ff, nb_daemon_in;
   ttbl_pkg::token_type   pb_daemon_ff, pb_daemon_in;
   ttbl_pkg::token_type   n_period_ff, n_period_in;
   ttbl_pkg::token_type   p_period_ff, p_period_in;
   ttbl_pkg::level_type   lvl_min_ff, lvl_min_in;

   ttbl_pkg::token_type   tokens_ff [4];
   ttbl_pkg::token_type   tokens_in [4];
   ttbl_pkg::tick_type    last_tick_ff [4];
   ttbl_pkg::tick_type    last_tick_in [4];
   ttbl_pkg::drop_type    drop_ff [2];
   ttbl_pkg::drop_type    drop_in [2];

   ttbl_pkg::bucket_type  bucket_ff, bucket_in;
   ttbl_pkg::level_type   level_ff, level_in;
   logic                  grp_ff, grp_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   ttbl_pkg::tick_type    tick_ff, tick_in;
   logic                  gt_ff, gt_in;
   logic                  gain_ge_ff, gain_ge_in;
   ttbl_pkg::token_type   gain_lo_ff, gain_lo_in;
   logic                  acc_ff, acc_in;
   logic                  used_prio_ff, used_prio_in;
   ttbl_pkg::drop_type    drops_out_ff, drops_out_in;

   ttbl_pkg::div_ctl_type div_ctl;
   ttbl_pkg::div_sts_type div_sts;
   logic [TIME_BITS-1:0]  div_dividend;

   ttbl_pkg::token_type   n_divisor;
   ttbl_pkg::token_type   p_divisor;
   ttbl_pkg::token_type   burst_sel;
   ttbl_pkg::token_type   tok_cur;
   ttbl_pkg::token_type   tok_new;
   ttbl_pkg::tick_type    stored_tick;
   ttbl_pkg::tick_type    gain;
   logic [TW:0]           sum;
   logic                  take_ok;
   logic                  retry;

   ttbl_div #(.TIME_BITS(TIME_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .sts      (div_sts)
   );

   // a zero period counts as one
   assign n_divisor = (n_period_ff == '0) ? TW'(1) : n_period_ff;
   assign p_divisor = (p_period_ff == '0) ? TW'(1) : p_period_ff;

   assign div_dividend = (state_ff == ttbl_pkg::ST_IDLE) ? req.now_ms : now_ff;

   // configuration decode
   always_comb begin
      nb_main_in   = nb_main_ff;
      pb_main_in   = pb_main_ff;
      nb_daemon_in = nb_daemon_ff;
      pb_daemon_in = pb_daemon_ff;
      n_period_in  = n_period_ff;
      p_period_in  = p_period_ff;
      lvl_min_in   = lvl_min_ff;
      if (csr_wr_en) begin
         unique case (ttbl_pkg::csr_index_type'(csr_index))
            ttbl_pkg::CSR_NORMAL_BURST_MAIN:     nb_main_in   = csr_wdata;
            ttbl_pkg::CSR_PRIORITY_BURST_MAIN:   pb_main_in   = csr_wdata;
            ttbl_pkg::CSR_NORMAL_BURST_DAEMON:   nb_daemon_in = csr_wdata;
            ttbl_pkg::CSR_PRIORITY_BURST_DAEMON: pb_daemon_in = csr_wdata;
            ttbl_pkg::CSR_NORMAL_TICK_PERIOD:    n_period_in  = csr_wdata;
            ttbl_pkg::CSR_PRIORITY_TICK_PERIOD:  p_period_in  = csr_wdata;
            ttbl_pkg::CSR_PRIORITY_LEVEL_MIN: begin
               lvl_min_in = csr_wdata[ttbl_pkg::LEVEL_BITS-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (bucket_ff)
         ttbl_pkg::BUCKET_MAIN_NORMAL:   burst_sel = nb_main_ff;
         ttbl_pkg::BUCKET_MAIN_PRIORITY: burst_sel = pb_main_ff;
         ttbl_pkg::BUCKET_DAEMON_NORMAL: burst_sel = nb_daemon_ff;
         default:                        burst_sel = pb_daemon_ff;
      endcase
   end

   assign tok_cur     = tokens_ff[bucket_ff];
   assign stored_tick = last_tick_ff[bucket_ff];
   assign gain        = tick_ff - stored_tick;
   assign sum         = {1'b0, tok_cur} + {1'b0, gain_lo_ff};

   // refill: gain below burst means the low bits of the gain are exact
   always_comb begin
      if (!gt_ff) begin
         tok_new = tok_cur;
      end else if (gain_ge_ff) begin
         tok_new = burst_sel;
      end else if (sum < {1'b0, burst_sel}) begin
         tok_new = sum[TW-1:0];
      end else begin
         tok_new = burst_sel;
      end
   end

   assign take_ok = tok_new != '0;
   assign retry   = !take_ok && !bucket_ff[0] && (level_ff >= lvl_min_ff);

   always_comb begin
      state_in     = state_ff;
      tokens_in    = tokens_ff;
      last_tick_in = last_tick_ff;
      drop_in      = drop_ff;
      bucket_in    = bucket_ff;
      level_in     = level_ff;
      grp_in       = grp_ff;
      now_in       = now_ff;
      tick_in      = tick_ff;
      gt_in        = gt_ff;
      gain_ge_in   = gain_ge_ff;
      gain_lo_in   = gain_lo_ff;
      acc_in       = acc_ff;
      used_prio_in = used_prio_ff;
      drops_out_in = drops_out_ff;
      div_ctl.start   = 1'b0;
      div_ctl.divisor = n_divisor;

      unique case (state_ff)
         ttbl_pkg::ST_IDLE: begin
            if (req.valid) begin
               level_in      = req.level;
               grp_in        = req.origin_id == ttbl_pkg::ORIGIN_DAEMON;
               bucket_in     = (req.origin_id == ttbl_pkg::ORIGIN_DAEMON) ?
                               ttbl_pkg::BUCKET_DAEMON_NORMAL : ttbl_pkg::BUCKET_MAIN_NORMAL;
               now_in        = req.now_ms;
               div_ctl.start = 1'b1;
               state_in      = ttbl_pkg::ST_DIV;
            end
         end
         ttbl_pkg::ST_DIV: begin
            if (div_sts.done) begin
               tick_in  = div_sts.quotient;
               state_in = ttbl_pkg::ST_REFILL;
            end
         end
         ttbl_pkg::ST_REFILL: begin
            gt_in      = tick_ff > stored_tick;
            gain_ge_in = gain >= ttbl_pkg::TICK_BITS'(burst_sel);
            gain_lo_in = gain[TW-1:0];
            state_in   = ttbl_pkg::ST_DECIDE;
         end
         ttbl_pkg::ST_DECIDE: begin
            if (take_ok) begin
               tokens_in[bucket_ff]    = tok_new - TW'(1);
               last_tick_in[bucket_ff] = tick_ff;
            end
            if (retry) begin
               bucket_in       = bucket_ff | ttbl_pkg::BUCKET_MAIN_PRIORITY;
               div_ctl.start   = 1'b1;
               div_ctl.divisor = p_divisor;
               state_in        = ttbl_pkg::ST_DIV;
            end else begin
               acc_in       = take_ok;
               used_prio_in = take_ok && bucket_ff[0];
               if (take_ok) begin
                  drops_out_in    = drop_ff[grp_ff];
                  drop_in[grp_ff] = '0;
               end else begin
                  drops_out_in = '0;
                  if (drop_ff[grp_ff] != ttbl_pkg::DROP_SATURATED) begin
                     drop_in[grp_ff] = drop_ff[grp_ff] + ttbl_pkg::DROP_BITS'(1);
                  end
               end
               state_in = ttbl_pkg::ST_RESP;
            end
         end
         ttbl_pkg::ST_RESP: begin
            if (rsp.ready) begin
               state_in = ttbl_pkg::ST_IDLE;
            end
         end
         default: state_in = ttbl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ttbl_pkg::ST_IDLE;
         nb_main_ff      <= ttbl_pkg::NORMAL_BURST_MAIN_RST;
         pb_main_ff      <= ttbl_pkg::PRIORITY_BURST_MAIN_RST;
         nb_daemon_ff    <= ttbl_pkg::NORMAL_BURST_DAEMON_RST;
         pb_daemon_ff    <= ttbl_pkg::PRIORITY_BURST_DAEMON_RST;
         n_period_ff     <= ttbl_pkg::NORMAL_TICK_PERIOD_RST;
         p_period_ff     <= ttbl_pkg::PRIORITY_TICK_PERIOD_RST;
         lvl_min_ff      <= ttbl_pkg::PRIORITY_LEVEL_MIN_RST;
         tokens_ff[0]    <= ttbl_pkg::NORMAL_BURST_MAIN_RST;
         tokens_ff[1]    <= ttbl_pkg::PRIORITY_BURST_MAIN_RST;
         tokens_ff[2]    <= ttbl_pkg::NORMAL_BURST_DAEMON_RST;
         tokens_ff[3]    <= ttbl_pkg::PRIORITY_BURST_DAEMON_RST;
         last_tick_ff[0] <= '0;
         last_tick_ff[1] <= '0;
         last_tick_ff[2] <= '0;
         last_tick_ff[3] <= '0;
         drop_ff[0]      <= '0;
         drop_ff[1]      <= '0;
      end else begin
         state_ff     <= state_in;
         nb_main_ff   <= nb_main_in;
         pb_main_ff   <= pb_main_in;
         nb_daemon_ff <= nb_daemon_in;
         pb_daemon_ff <= pb_daemon_in;
         n_period_ff  <= n_period_in;
         p_period_ff  <= p_period_in;
         lvl_min_ff   <= lvl_min_in;
         tokens_ff    <= tokens_in;
         last_tick_ff <= last_tick_in;
         drop_ff      <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff    <= bucket_in;
      level_ff     <= level_in;
      grp_ff       <= grp_in;
      now_ff       <= now_in;
      tick_ff      <= tick_in;
      gt_ff        <= gt_in;
      gain_ge_ff   <= gain_ge_in;
      gain_lo_ff   <= gain_lo_in;
      acc_ff       <= acc_in;
      used_prio_ff <= used_prio_in;
      drops_out_ff <= drops_out_in;
   end

   assign req.ready         = state_ff == ttbl_pkg::ST_IDLE;
   assign rsp.valid         = state_ff == ttbl_pkg::ST_RESP;
   assign rsp.accepted      = acc_ff;
   assign rsp.used_priority = used_prio_ff;
   assign rsp.drops_flushed = drops_out_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("request taken while a response is pending");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.accepted |-> !rsp.used_priority && rsp.drops_flushed == '0)
      else $error("rejected response carries priority or drop data");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready |=> req.ready)
      else $error("not ready after response transfer");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |=> state_ff == ttbl_pkg::ST_DIV && !div_sts.done)
      else $error("divider start outside a request");
`endif

endmodule
